>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_HOLDS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/ptb_pkg.sv
package ptb_pkg;

	// field widths
	localparam int OP_W     = 2;
	localparam int KEY_W    = 8;
	localparam int TIME_W   = 64;
	localparam int TOK_W    = 36;
	localparam int RATE_W   = 24;
	localparam int BURST_W  = 16;
	localparam int TOT_W    = 32;
	localparam int USE_W    = 9;

	// stream and config port widths
	localparam int IN_W     = 80;
	localparam int OUT_W    = 112;
	localparam int OUT_PAD  = OUT_W - (1 + TOK_W + TOT_W + TOT_W + USE_W);
	localparam int CFG_AW   = 1;
	localparam int CFG_DW   = 24;

	// number of distinct key codes
	localparam int KEY_SPAN = 256;

	// refill product split into two partial products
	localparam int HALF_W   = TOK_W / 2;
	localparam int PROD_W   = RATE_W + HALF_W;
	localparam int ACC_W    = RATE_W + TOK_W;
	localparam int SUM_W    = ACC_W + 1;

	localparam logic [TOK_W-1:0] MICRO_PER_TOKEN = TOK_W'(1000000);

	typedef enum logic [OP_W-1:0] {
		OP_PEEK,
		OP_ACQUIRE,
		OP_RESET_KEY,
		OP_CLEAR_ALL
	} opcode_t;

	typedef enum logic [CFG_AW-1:0] {
		REG_RATE,
		REG_BURST
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_ELAPSE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_COMMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic mem_rd;
		logic elapse;
		logic mul_lo;
		logic mul_hi;
		logic commit;
	} ptb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_stall;
	} ptb_status_t;

endpackage

>>> sv/per_key_token_bucket_limiter.sv
// channel  direction  handshake          payload, lowest bit first
// s_       in         s_tvalid/s_tready  opcode[1:0] key_index[9:2] now_us[73:10]
// m_       out        m_tvalid/m_tready  granted remaining_micro allowed_total
//                                        denied_total buckets_in_use
// cfg_     in         cfg_we             cfg_addr 0 rate_per_second, 1 bucket depth
//
// one item at a time: accept, memory read, elapsed time, two multiply passes, commit;
// the refill product shares one 24x18 multiplier.
// a result waits in the output register; the next item is taken meanwhile and
// holds at commit until that register is free.
// reset clears valid bits, totals and config; bucket contents need no reset.
`include "assert_macros.svh"

module per_key_token_bucket_limiter #(
	parameter int NUM_BUCKETS = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ptb_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [ptb_pkg::CFG_DW-1:0]  cfg_wdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// opcode, key_index, now_us, zero fill
	input  logic [ptb_pkg::IN_W-1:0]    s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// granted, remaining_micro, allowed_total, denied_total, buckets_in_use, zero fill
	output logic [ptb_pkg::OUT_W-1:0]   m_tdata
);
	import ptb_pkg::*;

	localparam int ENTRIES = (NUM_BUCKETS < KEY_SPAN) ? NUM_BUCKETS : KEY_SPAN;

	ptb_cmd_t    cmd;
	ptb_status_t status;

	ptb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.status   (status)
	);

	ptb_datapath #(
		.NUM_BUCKETS (NUM_BUCKETS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.status    (status)
	);

	// commit never overwrites a result that is still waiting
	`ASSERT_HOLDS(a_commit_free, cmd.commit |-> !(m_tvalid && !m_tready), "commit over held result")
	// only one item in flight
	`ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken while busy")
	// a new result appears only right after a commit
	`ASSERT_HOLDS(a_result_src, $rose(m_tvalid) |-> $past(cmd.commit), "result without commit")
	// bucket count stays within the table
	`ASSERT_HOLDS(a_used_range, m_tvalid |-> (m_tdata[109:101] <= USE_W'(ENTRIES)), "bucket count too high")

endmodule

>>> sv/ptb_ctrl.sv
module ptb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output ptb_pkg::ptb_cmd_t  cmd,
	input  ptb_pkg::ptb_status_t status
);
	import ptb_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.mem_rd = 1'b1;
				state_d    = ST_ELAPSE;
			end
			ST_ELAPSE: begin
				cmd.elapse = 1'b1;
				state_d    = ST_MUL_LO;
			end
			ST_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = ST_COMMIT;
			end
			ST_COMMIT: begin
				// hold until the result register is free
				if (!status.out_stall) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> sv/ptb_datapath.sv
module ptb_datapath #(
	parameter int NUM_BUCKETS = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ptb_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [ptb_pkg::CFG_DW-1:0]   cfg_wdata,
	input  logic [ptb_pkg::IN_W-1:0]     s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [ptb_pkg::OUT_W-1:0]    m_tdata,
	input  ptb_pkg::ptb_cmd_t            cmd,
	output ptb_pkg::ptb_status_t         status
);
	import ptb_pkg::*;

	// only the first KEY_SPAN buckets can be addressed by an 8-bit key
	localparam int ENTRIES = (NUM_BUCKETS < KEY_SPAN) ? NUM_BUCKETS : KEY_SPAN;
	localparam int AW      = $clog2(ENTRIES);
	localparam int MEM_W   = TIME_W + TOK_W;

	// configuration
	logic [RATE_W-1:0] rate_q;
	logic [TOK_W-1:0]  cap_q;

	// request registers
	opcode_t           op_q;
	logic [AW-1:0]     key_q;
	logic [TIME_W-1:0] now_q;

	// bucket store
	logic [MEM_W-1:0]  mem [ENTRIES];
	logic [MEM_W-1:0]  rd_q;
	logic              vld_q [ENTRIES];

	// refill arithmetic
	logic [TOK_W-1:0]  tok_q;
	logic [TOK_W-1:0]  el_q;
	logic              sat_q;
	logic              new_q;
	logic [ACC_W-1:0]  acc_q;
	logic [PROD_W-1:0] prod;
	logic [HALF_W-1:0] mul_op;
	logic [TIME_W-1:0] elapsed;
	logic [SUM_W-1:0]  sum;
	logic [TOK_W-1:0]  refill;
	logic              has_token;

	// totals and result
	logic [TOT_W-1:0]  allowed_q;
	logic [TOT_W-1:0]  denied_q;
	logic [USE_W-1:0]  used_q;
	logic [TOK_W-1:0]  rem_q;
	logic              granted_q;
	logic              out_valid_q;
	logic [TOK_W-1:0]  fill;
	logic              fill_grant;

	// key folding table
	logic [AW-1:0]     key_map [KEY_SPAN];

	for (genvar gi = 0; gi < KEY_SPAN; gi++) begin : g_key_map
		assign key_map[gi] = AW'(gi % ENTRIES);
	end

	// configuration writes, capacity scaled once per write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= '0;
			cap_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_RATE:  rate_q <= cfg_wdata[RATE_W-1:0];
				REG_BURST: cap_q  <= TOK_W'(cfg_wdata[BURST_W-1:0]) * MICRO_PER_TOKEN;
				default:   rate_q <= rate_q;
			endcase
		end
	end

	// capture the request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode_t'(s_tdata[OP_W-1:0]);
			key_q <= key_map[s_tdata[OP_W +: KEY_W]];
			now_q <= s_tdata[OP_W+KEY_W +: TIME_W];
		end
	end

	// bucket memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			rd_q <= mem[key_q];
		end
		if (cmd.commit && (op_q != OP_CLEAR_ALL)) begin
			mem[key_q] <= {now_q, fill};
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (cmd.commit) begin
			if (op_q == OP_CLEAR_ALL) begin
				for (int i = 0; i < ENTRIES; i++) begin
					vld_q[i] <= 1'b0;
				end
			end else begin
				vld_q[key_q] <= 1'b1;
			end
		end
	end

	// elapsed time, a fresh bucket starts full with no elapsed time
	assign elapsed = now_q - rd_q[TOK_W +: TIME_W];

	always_ff @(posedge clk) begin
		if (cmd.elapse) begin
			new_q <= !vld_q[key_q];
			if (!vld_q[key_q]) begin
				tok_q <= cap_q;
				el_q  <= '0;
				sat_q <= 1'b0;
			end else begin
				tok_q <= rd_q[TOK_W-1:0];
				el_q  <= elapsed[TOK_W-1:0];
				sat_q <= (|elapsed[TIME_W-1:TOK_W]) && (rate_q != '0);
			end
		end
	end

	// one shared multiplier over two halves of the elapsed time
	assign mul_op = cmd.mul_hi ? el_q[TOK_W-1:HALF_W] : el_q[HALF_W-1:0];
	assign prod   = rate_q * mul_op;

	always_ff @(posedge clk) begin
		if (cmd.mul_lo) begin
			acc_q <= ACC_W'(prod);
		end else if (cmd.mul_hi) begin
			acc_q <= acc_q + {prod, {HALF_W{1'b0}}};
		end
	end

	// refill capped at capacity
	assign sum       = SUM_W'(tok_q) + SUM_W'(acc_q);
	assign refill    = (sat_q || (sum > SUM_W'(cap_q))) ? cap_q : sum[TOK_W-1:0];
	assign has_token = (refill >= MICRO_PER_TOKEN);

	// fill and grant after the operation
	always_comb begin
		fill       = refill;
		fill_grant = has_token;
		case (op_q)
			OP_PEEK: begin
				fill = refill;
			end
			OP_ACQUIRE: begin
				if (has_token) begin
					fill = refill - MICRO_PER_TOKEN;
				end
			end
			OP_RESET_KEY: begin
				fill       = cap_q;
				fill_grant = 1'b0;
			end
			OP_CLEAR_ALL: begin
				fill       = '0;
				fill_grant = 1'b0;
			end
			default: begin
				fill = refill;
			end
		endcase
	end

	// totals and bucket count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allowed_q <= '0;
			denied_q  <= '0;
			used_q    <= '0;
		end else if (cmd.commit) begin
			if (op_q == OP_CLEAR_ALL) begin
				used_q <= '0;
			end else if (new_q) begin
				used_q <= used_q + 1'b1;
			end
			if (op_q == OP_ACQUIRE) begin
				if (has_token && (allowed_q != '1)) begin
					allowed_q <= allowed_q + 1'b1;
				end
				if (!has_token && (denied_q != '1)) begin
					denied_q <= denied_q + 1'b1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rem_q     <= fill;
			granted_q <= fill_grant;
		end
	end

	// totals change only at commit, so they are read straight from the counters
	assign m_tvalid         = out_valid_q;
	assign m_tdata          = {{OUT_PAD{1'b0}}, used_q, denied_q, allowed_q, rem_q, granted_q};
	assign status.out_stall = out_valid_q && !m_tready;

endmodule
